// File: hdl/lpat_pkg.sv
`default_nettype none
package lpat_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 8;
    localparam int CODE_W   = 2;

    // milliseconds per second and the press threshold in milliseconds
    localparam int MS_PER_SECOND = 1000;
    localparam int THRESH_W      = HOLD_W + $clog2(MS_PER_SECOND);
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(3);

    // operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = OP_W'(0);
    localparam logic [OP_W-1:0] OP_POLL   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(2);

    // poll result codes
    localparam logic [CODE_W-1:0] CODE_NONE      = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_PRIMARY   = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_SECONDARY = CODE_W'(2);

    // request from the top level to one press tracker
    typedef struct packed {
        logic enable;
        logic pressed;
    } track_req_t;

    // hold seconds to threshold in milliseconds
    function automatic logic [THRESH_W-1:0] hold_to_thresh(input logic [HOLD_W-1:0] hold);
        logic [THRESH_W-1:0] product;
        begin
            product = THRESH_W'(hold) * THRESH_W'(MS_PER_SECOND);
            return product;
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/lpat_if.sv
`default_nettype none
interface lpat_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpat_pkg::OP_W-1:0]     operation;
    logic                          primary_pressed;
    logic                          secondary_pressed;
    logic [lpat_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output operation, output primary_pressed,
                    output secondary_pressed, output now_ms, input ready);
    modport sink   (input valid, input operation, input primary_pressed,
                    input secondary_pressed, input now_ms, output ready);
endinterface

interface lpat_out_if;
    logic                          valid;
    logic                          ready;
    logic                          primary_alert;
    logic                          secondary_alert;
    logic                          primary_changed;
    logic                          secondary_changed;
    logic [lpat_pkg::CODE_W-1:0]   event_code;

    modport source (output valid, output primary_alert, output secondary_alert,
                    output primary_changed, output secondary_changed,
                    output event_code, input ready);
    modport sink   (input valid, input primary_alert, input secondary_alert,
                    input primary_changed, input secondary_changed,
                    input event_code, output ready);
endinterface
`default_nettype wire

// File: hdl/lpat_tracker.sv
`default_nettype none
module lpat_tracker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lpat_pkg::track_req_t           req,
    input  wire logic [lpat_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [lpat_pkg::THRESH_W-1:0]  thresh,
    output logic                                toggle
);
    import lpat_pkg::*;

    logic              held_reg;
    logic              held_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] elapsed;
    logic              press_begin;
    logic              press_end;

    // press edges against the held state
    assign press_begin = req.enable && req.pressed && !held_reg;
    assign press_end   = req.enable && !req.pressed && held_reg;

    // elapsed time wraps with the free-running clock
    assign elapsed = now_ms - start_reg;
    assign toggle  = press_end && (elapsed >= TIME_W'(thresh));

    always_comb
    begin
        held_next = held_reg;
        if (press_begin)
        begin
            held_next = 1'b1;
        end
        else if (press_end)
        begin
            held_next = 1'b0;
        end
    end

    // held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    // press start time
    always_ff @(posedge clk)
    begin
        if (press_begin)
        begin
            start_reg <= now_ms;
        end
    end

endmodule
`default_nettype wire

// File: hdl/long_press_alert_toggle_unit.sv
`default_nettype none
// path: an accepted request item goes into the request register, then its report into the report register
// throughput: one item per cycle while each report is taken, set by the tracker update and flag logic
// the request register takes one more item while a report waits in the output register,
// then the request side stalls until the report is taken
// reset: asynchronous, active low; clears pipeline valids, press trackers and alert flags,
// and sets the hold time to 3 seconds
module long_press_alert_toggle_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    lpat_in_if.sink                           request,
    lpat_out_if.source                        report,
    input  wire logic                         cfg_we,
    input  wire logic [lpat_pkg::HOLD_W-1:0]  cfg_wdata
);
    import lpat_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;

    logic              s1_valid_reg;
    logic [OP_W-1:0]   s1_op_reg;
    logic              s1_pp_reg;
    logic              s1_sp_reg;
    logic [TIME_W-1:0] s1_now_reg;

    logic              out_valid_reg;
    logic              out_pa_reg;
    logic              out_sa_reg;
    logic              out_pc_reg;
    logic              out_sc_reg;
    logic [CODE_W-1:0] out_code_reg;

    logic              pflag_reg;
    logic              pflag_next;
    logic              sflag_reg;
    logic              sflag_next;
    logic [CODE_W-1:0] code_next;

    logic       out_free;
    logic       s1_adv;
    logic       take;
    logic       is_sample;
    track_req_t p_req;
    track_req_t s_req;
    logic       p_toggle;
    logic       s_toggle;

    // handshake
    assign out_free      = !out_valid_reg || report.ready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign request.ready = !s1_valid_reg || out_free;
    assign take          = request.valid && request.ready;

    // hold threshold in milliseconds, worked out at write time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= hold_to_thresh(HOLD_RESET);
        end
        else if (cfg_we)
        begin
            thresh_reg <= hold_to_thresh(cfg_wdata);
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg  <= request.operation;
            s1_pp_reg  <= request.primary_pressed;
            s1_sp_reg  <= request.secondary_pressed;
            s1_now_reg <= request.now_ms;
        end
    end

    // press trackers
    assign is_sample     = s1_adv && (s1_op_reg == OP_SAMPLE);
    assign p_req.enable  = is_sample;
    assign p_req.pressed = s1_pp_reg;
    assign s_req.enable  = is_sample;
    assign s_req.pressed = s1_sp_reg;

    lpat_tracker u_primary (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (p_req),
        .now_ms (s1_now_reg),
        .thresh (thresh_reg),
        .toggle (p_toggle)
    );

    lpat_tracker u_secondary (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (s_req),
        .now_ms (s1_now_reg),
        .thresh (thresh_reg),
        .toggle (s_toggle)
    );

    // alert flags and poll result
    always_comb
    begin
        pflag_next = pflag_reg;
        sflag_next = sflag_reg;
        code_next  = CODE_NONE;
        unique case (s1_op_reg)
            OP_SAMPLE:
            begin
                pflag_next = pflag_reg ^ p_toggle;
                sflag_next = sflag_reg ^ s_toggle;
            end
            OP_POLL:
            begin
                if (pflag_reg)
                begin
                    pflag_next = 1'b0;
                    code_next  = CODE_PRIMARY;
                end
                else if (sflag_reg)
                begin
                    sflag_next = 1'b0;
                    code_next  = CODE_SECONDARY;
                end
            end
            OP_CLEAR:
            begin
                pflag_next = 1'b0;
                sflag_next = 1'b0;
            end
            default:
            begin
                pflag_next = pflag_reg;
                sflag_next = sflag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pflag_reg <= 1'b0;
            sflag_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            pflag_reg <= pflag_next;
            sflag_reg <= sflag_next;
        end
    end

    // report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pa_reg   <= pflag_next;
            out_sa_reg   <= sflag_next;
            out_pc_reg   <= is_sample && p_toggle;
            out_sc_reg   <= is_sample && s_toggle;
            out_code_reg <= code_next;
        end
    end

    assign report.valid             = out_valid_reg;
    assign report.primary_alert     = out_pa_reg;
    assign report.secondary_alert   = out_sa_reg;
    assign report.primary_changed   = out_pc_reg;
    assign report.secondary_changed = out_sc_reg;
    assign report.event_code        = out_code_reg;

    // checks
    a_no_change_off_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_op_reg != OP_SAMPLE) |=> !out_pc_reg && !out_sc_reg)
        else $error("change pulse on an item that is not a sample");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_op_reg == OP_CLEAR) |=> !pflag_reg && !sflag_reg)
        else $error("clear left an alert set");

    a_poll_primary_first: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_op_reg == OP_POLL) && pflag_reg
        |=> !pflag_reg && $stable(sflag_reg) && (out_code_reg == CODE_PRIMARY))
        else $error("poll did not take the primary alert alone");

    a_report_mirrors_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pa_reg == pflag_reg) && (out_sa_reg == sflag_reg))
        else $error("waiting report differs from the alert flags");

endmodule
`default_nettype wire
